>>> rtl/mso_pkg.sv
`default_nettype none

package mso_pkg;

    // Defaults for the top-level parameters
    localparam int NUM_CHANNELS_DEF = 8;
    localparam int TABLE_BITS_DEF   = 10;

    // Field widths
    localparam int CH_W     = 3;
    localparam int PHASE_W  = 32;
    localparam int AMP_W    = 16;
    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 15;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    // pi/2 in Q30, truncated
    localparam longint unsigned PIH_Q30 = 64'd1686629713;

    // Word handed from the front to the back: channel, full phase, gain and offset
    typedef struct packed {
        logic [CH_W-1:0]            channel;
        logic [PHASE_W-1:0]         phase;
        logic signed [AMP_W-1:0]    amplitude;
        logic signed [SAMPLE_W-1:0] dc_offset;
    } mso_item_t;

    // One quarter-wave entry: Taylor series of sin to the x^17 term in Q30,
    // scaled to 32767 with rounding and clamped.
    function automatic logic [MAG_W-1:0] sine_entry(input int unsigned k,
                                                    input int unsigned table_bits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned v;
        longint          s;
        int              n;
        x    = (PIH_Q30 * 64'(k)) >> (table_bits - 2);
        x2   = (x * x) >> 30;
        term = x;
        s    = longint'(x);
        for (n = 1; n <= 8; n++)
        begin
            term = (term * x2) >> 30;
            case (n)
                1: term = term / 6;
                2: term = term / 20;
                3: term = term / 42;
                4: term = term / 72;
                5: term = term / 110;
                6: term = term / 156;
                7: term = term / 210;
                default: term = term / 272;
            endcase
            if (n[0])
                s = s - longint'(term);
            else
                s = s + longint'(term);
        end
        if (s < 0)
            s = 0;
        v = (64'(s) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767)
            v = 64'd32767;
        return MAG_W'(v);
    endfunction

endpackage

`default_nettype wire

>>> rtl/mso_ram.sv
`default_nettype none

// Simple dual-port RAM, registered read, old data on read-during-write
module mso_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/mso_front.sv
`default_nettype none

// Front: accepts words, reads and advances the channel accumulator,
// forms the full phase and pushes it into the queue.
module mso_front #(
    parameter int NUM_CHANNELS = mso_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [mso_pkg::CH_W-1:0]             channel,
    input  wire logic [mso_pkg::PHASE_W-1:0]          freq_step,
    input  wire logic signed [mso_pkg::AMP_W-1:0]     amplitude,
    input  wire logic [mso_pkg::PHASE_W-1:0]          phase_offset,
    input  wire logic signed [mso_pkg::SAMPLE_W-1:0]  dc_offset,
    input  wire logic [mso_pkg::FIFO_CNT_W-1:0]       fifo_count,
    output logic                                      push,
    output mso_pkg::mso_item_t                        push_item
);

    import mso_pkg::*;

    localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int EXT_W  = ((ADDR_W > CH_W) ? ADDR_W : CH_W) + 1;
    localparam int OCC_W  = FIFO_CNT_W + 1;

    logic                       s1_valid_reg;
    logic [CH_W-1:0]            s1_ch_reg;
    logic [PHASE_W-1:0]         s1_step_reg;
    logic signed [AMP_W-1:0]    s1_amp_reg;
    logic [PHASE_W-1:0]         s1_poff_reg;
    logic signed [SAMPLE_W-1:0] s1_dc_reg;
    logic                       s1_fwd_reg;
    logic [PHASE_W-1:0]         last_acc_reg;
    logic [NUM_CHANNELS-1:0]    acc_vld_reg;

    logic                       accept;
    logic [EXT_W-1:0]           in_ext;
    logic [EXT_W-1:0]           s1_ext;
    logic                       in_hit;
    logic                       s1_hit;
    logic [ADDR_W-1:0]          in_addr;
    logic [ADDR_W-1:0]          s1_addr;
    logic [PHASE_W-1:0]         ram_rdata;
    logic [PHASE_W-1:0]         acc;
    logic [PHASE_W-1:0]         acc_new;
    logic                       acc_we;
    logic [OCC_W-1:0]           occupancy;

    // Room for this word and the one in flight
    assign occupancy = OCC_W'(fifo_count) + OCC_W'(s1_valid_reg);
    assign in_ready  = occupancy < OCC_W'(FIFO_DEPTH);
    assign accept    = in_valid && in_ready;

    // Channel range checks and accumulator addresses
    assign in_ext  = EXT_W'(channel);
    assign s1_ext  = EXT_W'(s1_ch_reg);
    assign in_hit  = in_ext < EXT_W'(NUM_CHANNELS);
    assign s1_hit  = s1_ext < EXT_W'(NUM_CHANNELS);
    assign in_addr = in_ext[ADDR_W-1:0];
    assign s1_addr = s1_ext[ADDR_W-1:0];

    mso_ram #(
        .WIDTH (PHASE_W),
        .DEPTH (NUM_CHANNELS)
    ) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (s1_addr),
        .wdata (acc_new),
        .re    (accept),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    // Accumulator: forwarded from the word just ahead, else RAM, else reset zero
    always_comb
    begin
        acc = '0;
        if (s1_hit)
        begin
            if (s1_fwd_reg)
                acc = last_acc_reg;
            else if (acc_vld_reg[s1_addr])
                acc = ram_rdata;
        end
    end

    assign acc_new = acc + s1_step_reg;
    assign acc_we  = s1_valid_reg && s1_hit;

    assign push                = s1_valid_reg;
    assign push_item.channel   = s1_ch_reg;
    assign push_item.phase     = acc + s1_poff_reg;
    assign push_item.amplitude = s1_amp_reg;
    assign push_item.dc_offset = s1_dc_reg;

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            acc_vld_reg  <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (acc_we)
                acc_vld_reg[s1_addr] <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ch_reg   <= channel;
            s1_step_reg <= freq_step;
            s1_amp_reg  <= amplitude;
            s1_poff_reg <= phase_offset;
            s1_dc_reg   <= dc_offset;
            s1_fwd_reg  <= s1_valid_reg && in_hit && (s1_ch_reg == channel);
        end
        if (s1_valid_reg)
            last_acc_reg <= acc_new;
    end

endmodule

`default_nettype wire

>>> rtl/mso_fifo.sv
`default_nettype none

// Short queue between front and back
module mso_fifo (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    input  wire mso_pkg::mso_item_t             push_item,
    input  wire logic                           pop,
    output logic                                pop_valid,
    output mso_pkg::mso_item_t                  pop_item,
    output logic [mso_pkg::FIFO_CNT_W-1:0]      count
);

    import mso_pkg::*;

    mso_item_t             slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic                  do_pop;

    assign pop_valid = count_reg != '0;
    assign do_pop    = pop && pop_valid;
    assign pop_item  = slot_reg[rd_ptr_reg];
    assign count     = count_reg;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (!push && do_pop)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

>>> rtl/mso_back.sv
`default_nettype none

// Back: quarter-wave lookup, gain multiply, round, offset and saturate
module mso_back #(
    parameter int TABLE_BITS = mso_pkg::TABLE_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 item_valid,
    input  wire mso_pkg::mso_item_t                   item,
    output logic                                      item_pop,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [mso_pkg::CH_W-1:0]                  channel_out,
    output logic signed [mso_pkg::SAMPLE_W-1:0]       sample
);

    import mso_pkg::*;

    localparam int QUARTER = 2 ** (TABLE_BITS - 2);
    localparam int FRAC_W  = TABLE_BITS - 2;
    localparam int IDX_W   = TABLE_BITS - 1;
    localparam int PROD_W  = 2 * AMP_W;
    localparam int RND_W   = PROD_W + 1;
    localparam int SCL_W   = RND_W - (AMP_W - 1);
    localparam int SUM_W   = SCL_W + 1;

    typedef logic [QUARTER:0][MAG_W-1:0] rom_t;

    function automatic rom_t build_rom();
        rom_t r;
        int   k;
        for (k = 0; k <= QUARTER; k++)
            r[k] = sine_entry(unsigned'(k), unsigned'(TABLE_BITS));
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic                       advance;
    logic [FRAC_W-1:0]          frac;
    logic [IDX_W-1:0]           idx;

    logic                       b1_valid_reg;
    logic [CH_W-1:0]            b1_ch_reg;
    logic                       b1_neg_reg;
    logic [MAG_W-1:0]           b1_mag_reg;
    logic signed [AMP_W-1:0]    b1_amp_reg;
    logic signed [SAMPLE_W-1:0] b1_dc_reg;

    logic signed [AMP_W-1:0]    sine;
    logic                       b2_valid_reg;
    logic [CH_W-1:0]            b2_ch_reg;
    logic signed [PROD_W-1:0]   b2_prod_reg;
    logic signed [SAMPLE_W-1:0] b2_dc_reg;

    logic signed [RND_W-1:0]    rounded;
    logic signed [SCL_W-1:0]    scaled;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SAMPLE_W-1:0] sat;

    logic                       out_valid_reg;
    logic [CH_W-1:0]            out_ch_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;

    // Whole pipeline moves unless the output word is held
    assign advance  = !out_valid_reg || out_ready;
    assign item_pop = advance;

    // Quarter-wave index: mirrored in odd quadrants
    assign frac = item.phase[PHASE_W-3 -: FRAC_W];
    assign idx  = item.phase[PHASE_W-2] ? (IDX_W'(QUARTER) - IDX_W'(frac)) : IDX_W'(frac);

    // Sign from the upper half cycle
    assign sine = b1_neg_reg ? -$signed({1'b0, b1_mag_reg}) : $signed({1'b0, b1_mag_reg});

    // Round half up to sample units, add offset, clamp
    assign rounded = RND_W'(b2_prod_reg) + RND_W'(1 << (AMP_W - 2));
    assign scaled  = rounded[RND_W-1 -: SCL_W];
    assign sum     = SUM_W'(scaled) + SUM_W'(b2_dc_reg);

    always_comb
    begin
        if (sum > SUM_W'(32767))
            sat = 16'sh7FFF;
        else if (sum < -SUM_W'(32768))
            sat = 16'sh8000;
        else
            sat = sum[SAMPLE_W-1:0];
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b1_valid_reg  <= item_valid;
            b2_valid_reg  <= b1_valid_reg;
            out_valid_reg <= b2_valid_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b1_ch_reg      <= item.channel;
            b1_neg_reg     <= item.phase[PHASE_W-1];
            b1_mag_reg     <= SINE_ROM[idx];
            b1_amp_reg     <= item.amplitude;
            b1_dc_reg      <= item.dc_offset;
            b2_ch_reg      <= b1_ch_reg;
            b2_prod_reg    <= b1_amp_reg * sine;
            b2_dc_reg      <= b1_dc_reg;
            out_ch_reg     <= b2_ch_reg;
            out_sample_reg <= sat;
        end
    end

    assign out_valid   = out_valid_reg;
    assign channel_out = out_ch_reg;
    assign sample      = out_sample_reg;

endmodule

`default_nettype wire

>>> rtl/multichannel_sine_oscillator.sv
`default_nettype none

// Multichannel sine oscillator (DDS/NCO). Each input word names a channel and
// carries a frequency step, a Q1.15 gain, a phase offset and a DC offset; the
// block returns sat16(round(gain * sin(2*pi*(acc + phase_offset))) + dc_offset)
// and then advances that channel's 32-bit phase accumulator by the step.
// Accumulators live in a small RAM that reset marks empty (they read as zero)
// and a word for the same channel in the next cycle gets the new value by
// forwarding, so one word is accepted every cycle while the queue has room,
// in any channel order. The front reads and updates the accumulator, the back
// does quarter-wave table lookup, multiply, round and saturate; a four-word
// queue between them lets either side stall. Channels at or above NUM_CHANNELS
// use a zero accumulator (phase = phase offset) and leave no state behind.
// The sine table has 2^(TABLE_BITS-2)+1 entries, no interpolation.
module multichannel_sine_oscillator #(
    parameter int NUM_CHANNELS = mso_pkg::NUM_CHANNELS_DEF,
    parameter int TABLE_BITS   = mso_pkg::TABLE_BITS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // channel, freq_step, amplitude, phase_offset, dc_offset, zero pad
    input  wire logic [103:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // channel_out, sample, zero pad
    output logic [23:0]       m_tdata
);

    import mso_pkg::*;

    mso_item_t              push_item;
    mso_item_t              pop_item;
    logic                   push;
    logic                   pop;
    logic                   pop_valid;
    logic [FIFO_CNT_W-1:0]  fifo_count;
    logic [CH_W-1:0]        channel_out;
    logic [SAMPLE_W-1:0]    sample;

    mso_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .channel      (s_tdata[2:0]),
        .freq_step    (s_tdata[34:3]),
        .amplitude    (s_tdata[50:35]),
        .phase_offset (s_tdata[82:51]),
        .dc_offset    (s_tdata[98:83]),
        .fifo_count   (fifo_count),
        .push         (push),
        .push_item    (push_item)
    );

    mso_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_item  (pop_item),
        .count     (fifo_count)
    );

    mso_back #(
        .TABLE_BITS (TABLE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (pop_valid),
        .item        (pop_item),
        .item_pop    (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .channel_out (channel_out),
        .sample      (sample)
    );

    assign m_tdata = {5'b0, sample, channel_out};

endmodule

`default_nettype wire
